// ----- rtl/upd_pkg.sv -----
// Shared types and character constants for the URL percent decoder.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } in_beat_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       end_of_string;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/upd_step.sv -----
// Combinational decode of one encoded byte against the current escape state.
// Depends on upd_pkg for the beat types, the phase codes and the character constants.
`default_nettype none

module upd_step (
    input  wire  upd_pkg::in_beat_t  beat,
    input  wire  upd_pkg::phase_t    phase,
    input  wire  logic [3:0]         high_nibble,
    input  wire  logic               plus_to_space,
    output upd_pkg::out_beat_t       result,
    output upd_pkg::phase_t          phase_next,
    output logic [3:0]               high_nibble_next
);

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        case (b) inside
            [8'h30:8'h39]: v = b[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: v = b[3:0] + 4'd9;
            default:       v = 4'd0;
        endcase
        return v;
    endfunction

    logic [3:0] digit;
    logic [7:0] decoded;

    assign digit   = hex_value(beat.in_byte);
    assign decoded = {high_nibble, digit};

    always_comb
    begin
        result.byte_valid    = 1'b0;
        result.out_byte      = 8'd0;
        result.end_of_string = beat.is_final;
        phase_next           = upd_pkg::PH_IDLE;
        high_nibble_next     = high_nibble;
        case (phase)
            upd_pkg::PH_HIGH:
            begin
                high_nibble_next = digit;
                phase_next       = upd_pkg::PH_LOW;
            end
            upd_pkg::PH_LOW:
            begin
                if (decoded != 8'd0)
                begin
                    result.byte_valid = 1'b1;
                    result.out_byte   = decoded;
                end
            end
            default:
            begin
                if (beat.in_byte == upd_pkg::CH_PERCENT)
                begin
                    phase_next       = upd_pkg::PH_HIGH;
                    high_nibble_next = 4'd0;
                end
                else
                begin
                    result.byte_valid = 1'b1;
                    if (plus_to_space && beat.in_byte == upd_pkg::CH_PLUS)
                        result.out_byte = upd_pkg::CH_SPACE;
                    else
                        result.out_byte = beat.in_byte;
                end
            end
        endcase
        if (beat.is_final)
            phase_next = upd_pkg::PH_IDLE;
    end

endmodule

`default_nettype wire

// ----- rtl/url_percent_decoder_core.sv -----
// Top level of the URL percent decoder: input register, decode step, result register.
// Depends on upd_pkg and upd_step.
//
// The input channel (in_valid, in_stall, in_beat) carries one encoded byte per
// beat with a flag on the string's last byte. The output channel (out_valid,
// out_stall, out_beat) carries exactly one result beat per input beat, in order.
// A result beat holds a valid flag, the decoded byte (zero when not valid) and
// a copy of the end-of-string flag.
// A beat accepted at a clock edge is registered in the input register, decoded,
// and taken into the result register, which drives the output. Throughput is
// one beat per cycle while the receiver does not stall; the escape state is
// updated as each beat moves from the input register to the result register.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more; in_stall rises only while both are full.
// Reset clears both registers, the escape state, and sets plus_to_space to 1.
// cfg_write with cfg_data sets plus_to_space; write it only while idle.
`default_nettype none

module url_percent_decoder_core (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               cfg_write,
    input  wire  logic               cfg_data,
    input  wire  logic               in_valid,
    output logic                     in_stall,
    input  wire  upd_pkg::in_beat_t  in_beat,
    output logic                     out_valid,
    input  wire  logic               out_stall,
    output upd_pkg::out_beat_t       out_beat
);

    logic               plus_reg;
    logic               s1_valid_reg;
    upd_pkg::in_beat_t  s1_beat_reg;
    logic               out_valid_reg;
    upd_pkg::out_beat_t out_beat_reg;
    upd_pkg::phase_t    phase_reg;
    logic [3:0]         high_reg;

    upd_pkg::out_beat_t result_next;
    upd_pkg::phase_t    phase_next;
    logic [3:0]         high_next;
    logic               advance;
    logic               in_take;

    upd_step u_step (
        .beat             (s1_beat_reg),
        .phase            (phase_reg),
        .high_nibble      (high_reg),
        .plus_to_space    (plus_reg),
        .result           (result_next),
        .phase_next       (phase_next),
        .high_nibble_next (high_next)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_reg      <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= upd_pkg::PH_IDLE;
            high_reg      <= 4'd0;
        end
        else
        begin
            if (cfg_write)
                plus_reg <= cfg_data;
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                high_reg      <= high_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_beat_reg <= in_beat;
        if (advance)
            out_beat_reg <= result_next;
    end

endmodule

`default_nettype wire

// ----- rtl/upd_checker.sv -----
// Port-level checks for url_percent_decoder_core, attached by a bind statement.
// Depends on upd_pkg for the beat types.
`default_nettype none

module upd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire upd_pkg::out_beat_t out_beat
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Result beat shown during reset.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("Input stalled without output backpressure.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_beat.byte_valid) |-> (out_beat.out_byte == 8'd0))
        else $error("Result without a byte carries a nonzero byte.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_beat)))
        else $error("Stalled result beat changed.");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
);

`default_nettype wire
